// ----- src/heat_diffusion_stencil_sweep_top_defines.svh -----
// ----------------------------------------------------------------------------
// Heat diffusion stencil sweep: assertion macros
// Shared concurrent assertion forms used by the stencil sweep RTL.
// ----------------------------------------------------------------------------
`ifndef HEAT_DIFFUSION_STENCIL_SWEEP_TOP_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_SWEEP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HDS_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hds: assertion failed");

// Next-cycle implication, disabled during reset.
`define HDS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hds: assertion failed");

`endif

// ----- src/hds_pkg.sv -----
// ----------------------------------------------------------------------------
// Heat diffusion stencil sweep package
// Payload structs, register codes and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hds_pkg;

   localparam int TEMP_BITS      = 16;  // Q8.8 temperature
   localparam int WEIGHT_BITS    = 16;  // Q0.16 weight
   localparam int GRID_BITS      = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int MIN_SIDE_LOG2  = 4;

   localparam logic [GRID_BITS-1:0]   RESET_GRID_LOG2 = 4'd4;
   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT    = 16'd7282;
   localparam logic [TEMP_BITS-1:0]   RESET_HOT       = 16'hFFFF;
   localparam logic [TEMP_BITS-1:0]   TEMP_MAX        = {TEMP_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_LOG2     = 3'd0,
      CSR_WEIGHT_CORNER = 3'd1,
      CSR_WEIGHT_SIDE   = 3'd2,
      CSR_WEIGHT_MIDDLE = 3'd3,
      CSR_HOT_VALUE     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TEMP_BITS-1:0] cell_temp;
      logic                 frame_start;
      logic                 flush;
   } req_payload_type;

   typedef struct packed {
      logic [TEMP_BITS-1:0] new_temp;
      logic                 frame_last;
   } rsp_payload_type;

   // Per-cell control that travels with the window down the pipe.
   typedef struct packed {
      logic emit;
      logic mask_top;
      logic mask_bottom;
      logic mask_left;
      logic mask_right;
      logic hot;
      logic last;
   } tap_ctrl_type;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight_corner;
      logic [WEIGHT_BITS-1:0] weight_side;
      logic [WEIGHT_BITS-1:0] weight_middle;
      logic [TEMP_BITS-1:0]   hot_value;
   } coef_type;

endpackage

// ----- src/heat_diffusion_stencil_sweep_top.sv -----
// ----------------------------------------------------------------------------
// Heat diffusion stencil sweep, top level
// One Jacobi sweep of a 3x3 heat stencil over an N-by-N grid streamed in
// raster order.
//
// Old cell temperatures (Q8.8) stream in on req_ in raster order, one item per
// clock when rsp_ is not stalled; new temperatures stream out on rsp_ in the same
// order, N+1 items behind the input, so N+1 flush items must follow the last cell
// to drain a sweep. The line buffers are two single-port-read, single-port-write
// row memories of 2^log2(MAX_SIDE) entries, read when an item is accepted and
// written back as the item leaves the first stage, so the sustained rate is one
// item per cycle while rsp_ is not stalled. Results pass the window, class-sum
// and product registers, then round and saturate into the output. A two-entry
// output buffer lets one more item in while a result waits. The row memories
// need no clearing after reset: entries never written only feed window taps that
// the border masking zeroes. Configuration is taken any cycle (csr_ready is
// always high) but must only be written while the block is idle; writing
// grid_log2 restarts the sweep. frame_start on an item restarts the sweep at that
// item; once N*N results are out, items give no result until the next
// frame_start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "heat_diffusion_stencil_sweep_top_defines.svh"

module heat_diffusion_stencil_sweep_top #(
   parameter int MAX_SIDE = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input items
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  hds_pkg::req_payload_type               req_payload,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output hds_pkg::rsp_payload_type               rsp_payload,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [hds_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [hds_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   // largest usable side is the biggest power of two that fits MAX_SIDE
   localparam int LOG_MAX = $clog2(MAX_SIDE + 1) - 1;
   localparam int COL_W   = LOG_MAX;          // column / output row-col index
   localparam int ROW_W   = LOG_MAX + 1;      // input row runs up to N
   localparam int IDX_W   = 2 * LOG_MAX + 1;  // output index runs up to N*N

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [hds_pkg::GRID_BITS-1:0] grid_log2_ff;
   hds_pkg::coef_type             coef_ff;
   logic                          csr_write;
   logic                          grid_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign grid_write = csr_write && (csr_index == hds_pkg::CSR_GRID_LOG2);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_log2_ff          <= hds_pkg::RESET_GRID_LOG2;
         coef_ff.weight_corner <= hds_pkg::RESET_WEIGHT;
         coef_ff.weight_side   <= hds_pkg::RESET_WEIGHT;
         coef_ff.weight_middle <= hds_pkg::RESET_WEIGHT;
         coef_ff.hot_value     <= hds_pkg::RESET_HOT;
      end else if (csr_write) begin
         unique case (csr_index)
            hds_pkg::CSR_GRID_LOG2: begin
               grid_log2_ff <= csr_wdata[hds_pkg::GRID_BITS-1:0];
            end
            hds_pkg::CSR_WEIGHT_CORNER: begin
               coef_ff.weight_corner <= csr_wdata[hds_pkg::WEIGHT_BITS-1:0];
            end
            hds_pkg::CSR_WEIGHT_SIDE: begin
               coef_ff.weight_side <= csr_wdata[hds_pkg::WEIGHT_BITS-1:0];
            end
            hds_pkg::CSR_WEIGHT_MIDDLE: begin
               coef_ff.weight_middle <= csr_wdata[hds_pkg::WEIGHT_BITS-1:0];
            end
            hds_pkg::CSR_HOT_VALUE: begin
               coef_ff.hot_value <= csr_wdata[hds_pkg::TEMP_BITS-1:0];
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Grid geometry: side clamped to [16, largest side that fits]
   // ------------------------------------------------------------------
   logic [hds_pkg::GRID_BITS-1:0] side_log2;
   logic [ROW_W-1:0]              side_n;
   logic [COL_W-1:0]              col_last;
   logic [IDX_W-1:0]              grid_total;
   logic [ROW_W-1:0]              hot_lo;
   logic [ROW_W-1:0]              hot_hi;

   always_comb begin
      if (grid_log2_ff < hds_pkg::GRID_BITS'(hds_pkg::MIN_SIDE_LOG2)) begin
         side_log2 = hds_pkg::GRID_BITS'(hds_pkg::MIN_SIDE_LOG2);
      end else if (grid_log2_ff > hds_pkg::GRID_BITS'(LOG_MAX)) begin
         side_log2 = hds_pkg::GRID_BITS'(LOG_MAX);
      end else begin
         side_log2 = grid_log2_ff;
      end
      side_n     = ROW_W'(1) << side_log2;
      col_last   = COL_W'(side_n - ROW_W'(1));
      grid_total = IDX_W'(1) << {side_log2, 1'b0};
      // hot square is [N/2 - N/16 - 1, N/2 + N/16 - 1) on both axes
      hot_lo     = (side_n >> 1) - (side_n >> 4) - ROW_W'(1);
      hot_hi     = (side_n >> 1) + (side_n >> 4) - ROW_W'(1);
   end

   // ------------------------------------------------------------------
   // Sweep position counters and per-item control
   // ------------------------------------------------------------------
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [IDX_W-1:0] out_index_ff, out_index_in;

   logic                          advance;
   logic                          accept;
   logic                          live;
   logic                          load;
   logic [ROW_W-1:0]              eff_row;
   logic [COL_W-1:0]              eff_col;
   logic [IDX_W-1:0]              eff_out;
   logic [COL_W-1:0]              out_row;
   logic [COL_W-1:0]              out_col;
   logic [hds_pkg::TEMP_BITS-1:0] load_temp;
   hds_pkg::tap_ctrl_type         load_ctrl;

   assign accept = req_valid && req_ready;
   assign load   = accept && live;

   always_comb begin
      // frame_start restarts the sweep before this item is placed
      eff_row = req_payload.frame_start ? '0 : in_row_ff;
      eff_col = req_payload.frame_start ? '0 : in_col_ff;
      eff_out = req_payload.frame_start ? '0 : out_index_ff;
      live    = eff_out < grid_total;

      // flush items and rows below the grid enter as zero
      if (req_payload.flush || (eff_row >= side_n)) begin
         load_temp = '0;
      end else begin
         load_temp = req_payload.cell_temp & hds_pkg::TEMP_MAX;
      end

      out_row = COL_W'(eff_out >> side_log2);
      out_col = COL_W'(eff_out) & col_last;

      // no result until the window is centered on cell zero
      load_ctrl.emit        = !((eff_row == '0) ||
                                ((eff_row == ROW_W'(1)) && (eff_col == '0)));
      load_ctrl.mask_top    = (out_row == '0);
      load_ctrl.mask_bottom = (out_row == col_last);
      load_ctrl.mask_left   = (out_col == '0);
      load_ctrl.mask_right  = (out_col == col_last);
      load_ctrl.hot         = ({1'b0, out_row} >= hot_lo) && ({1'b0, out_row} < hot_hi) &&
                              ({1'b0, out_col} >= hot_lo) && ({1'b0, out_col} < hot_hi);
      load_ctrl.last        = (eff_out == (grid_total - IDX_W'(1)));

      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      out_index_in = out_index_ff;
      if (accept) begin
         in_row_in    = eff_row;
         in_col_in    = eff_col;
         out_index_in = eff_out;
         if (live) begin
            if (eff_col == col_last) begin
               in_col_in = '0;
               in_row_in = eff_row + ROW_W'(1);
            end else begin
               in_col_in = eff_col + COL_W'(1);
            end
            if (load_ctrl.emit) begin
               out_index_in = eff_out + IDX_W'(1);
            end
         end
      end
      if (grid_write) begin
         in_row_in    = '0;
         in_col_in    = '0;
         out_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_index_ff <= '0;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_index_ff <= out_index_in;
      end
   end

   // ------------------------------------------------------------------
   // Datapath: line buffers + window, then multiply-accumulate
   // ------------------------------------------------------------------
   logic                               tap_valid;
   hds_pkg::tap_ctrl_type              tap_ctrl;
   logic [8:0][hds_pkg::TEMP_BITS-1:0] window_taps;
   logic                               mac_valid;
   hds_pkg::rsp_payload_type           mac_result;

   hds_window #(
      .COL_W (COL_W)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .load        (load),
      .load_col    (eff_col),
      .load_temp   (load_temp),
      .load_ctrl   (load_ctrl),
      .tap_valid   (tap_valid),
      .tap_ctrl    (tap_ctrl),
      .window_taps (window_taps)
   );

   hds_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .tap_valid   (tap_valid),
      .tap_ctrl    (tap_ctrl),
      .window_taps (window_taps),
      .coef        (coef_ff),
      .res_valid   (mac_valid),
      .res_payload (mac_result)
   );

   // ------------------------------------------------------------------
   // Output register plus skid entry. The pipe moves whenever the skid
   // entry is free; a result arriving against a stalled output parks there.
   // ------------------------------------------------------------------
   logic                     out_valid_ff, out_valid_in;
   hds_pkg::rsp_payload_type out_data_ff, out_data_in;
   logic                     skid_valid_ff, skid_valid_in;
   hds_pkg::rsp_payload_type skid_data_ff, skid_data_in;

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = mac_valid;
            out_data_in  = mac_result;
         end
      end else if (mac_valid && advance) begin
         skid_valid_in = 1'b1;
         skid_data_in  = mac_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `HDS_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `HDS_ASSERT_NEXT(a_stall_parks_result, clock, reset, out_valid_ff && !rsp_ready && mac_valid && advance, skid_valid_ff)
   `HDS_ASSERT_IMPLIES(a_out_index_bound, clock, reset, out_valid_ff || !out_valid_ff, out_index_ff <= grid_total)
   `HDS_ASSERT_IMPLIES(a_col_in_grid, clock, reset, out_valid_ff || !out_valid_ff, in_col_ff <= col_last)

endmodule

// ----- src/hds_window.sv -----
// ----------------------------------------------------------------------------
// Line buffers and 3x3 window
// Two row memories (read, then written back from stage one) feed the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hds_window #(
   parameter int COL_W = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 load,
   input  logic [COL_W-1:0]                     load_col,
   input  logic [hds_pkg::TEMP_BITS-1:0]        load_temp,
   input  hds_pkg::tap_ctrl_type                load_ctrl,
   output logic                                 tap_valid,
   output hds_pkg::tap_ctrl_type                tap_ctrl,
   output logic [8:0][hds_pkg::TEMP_BITS-1:0]   window_taps
);

   localparam int DEPTH = 2 ** COL_W;

   logic [hds_pkg::TEMP_BITS-1:0] row_above_mem   [DEPTH];
   logic [hds_pkg::TEMP_BITS-1:0] row_current_mem [DEPTH];

   logic [hds_pkg::TEMP_BITS-1:0]     top_rd_ff;
   logic [hds_pkg::TEMP_BITS-1:0]     mid_rd_ff;
   logic                              s1_valid_ff;
   logic [COL_W-1:0]                  s1_col_ff;
   logic [hds_pkg::TEMP_BITS-1:0]     s1_temp_ff;
   hds_pkg::tap_ctrl_type             s1_ctrl_ff;
   logic                              tap_valid_ff;
   hds_pkg::tap_ctrl_type             tap_ctrl_ff;
   logic [8:0][hds_pkg::TEMP_BITS-1:0] window_ff;
   logic                              fwd;
   logic                              wr_en;

   // back-to-back restarts can hit the column being written this cycle
   assign fwd   = s1_valid_ff && (s1_col_ff == load_col);
   assign wr_en = advance && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         if (fwd) begin
            top_rd_ff <= mid_rd_ff;
            mid_rd_ff <= s1_temp_ff;
         end else begin
            top_rd_ff <= row_above_mem[load_col];
            mid_rd_ff <= row_current_mem[load_col];
         end
      end
      if (wr_en) begin
         row_above_mem[s1_col_ff]   <= mid_rd_ff;
         row_current_mem[s1_col_ff] <= s1_temp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         tap_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= load;
         tap_valid_ff <= s1_valid_ff && s1_ctrl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_col_ff  <= load_col;
         s1_temp_ff <= load_temp;
         s1_ctrl_ff <= load_ctrl;
      end
      if (wr_en) begin
         tap_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (wr_en) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r*3]     <= window_ff[r*3 + 1];
            window_ff[r*3 + 1] <= window_ff[r*3 + 2];
         end
         window_ff[2] <= top_rd_ff;
         window_ff[5] <= mid_rd_ff;
         window_ff[8] <= s1_temp_ff;
      end
   end

   assign tap_valid   = tap_valid_ff;
   assign tap_ctrl    = tap_ctrl_ff;
   assign window_taps = window_ff;

endmodule

// ----- src/hds_mac.sv -----
// ----------------------------------------------------------------------------
// Stencil multiply-accumulate
// Masked class sums, three weight products, rounding, saturation, hot override.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hds_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 tap_valid,
   input  hds_pkg::tap_ctrl_type                tap_ctrl,
   input  logic [8:0][hds_pkg::TEMP_BITS-1:0]   window_taps,
   input  hds_pkg::coef_type                    coef,
   output logic                                 res_valid,
   output hds_pkg::rsp_payload_type             res_payload
);

   localparam int SUM_W  = hds_pkg::TEMP_BITS + 2;
   localparam int PROD_W = SUM_W + hds_pkg::WEIGHT_BITS;
   localparam int ACC_W  = PROD_W + 2;
   localparam int RES_W  = ACC_W - hds_pkg::WEIGHT_BITS;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (hds_pkg::WEIGHT_BITS - 1);

   logic [8:0][hds_pkg::TEMP_BITS-1:0] masked;
   logic [SUM_W-1:0]                   corner_sum;
   logic [SUM_W-1:0]                   side_sum;

   logic                          sum_valid_ff;
   logic [SUM_W-1:0]              corner_sum_ff;
   logic [SUM_W-1:0]              side_sum_ff;
   logic [SUM_W-1:0]              center_ff;
   logic                          sum_hot_ff;
   logic                          sum_last_ff;

   logic                          prod_valid_ff;
   logic [PROD_W-1:0]             corner_prod_ff;
   logic [PROD_W-1:0]             side_prod_ff;
   logic [PROD_W-1:0]             center_prod_ff;
   logic                          prod_hot_ff;
   logic                          prod_last_ff;

   logic [ACC_W-1:0]              acc;
   logic [RES_W-1:0]              rounded;
   logic [hds_pkg::TEMP_BITS-1:0] saturated;

   // zero the taps that fall outside the grid
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((r == 0 && tap_ctrl.mask_top) || (r == 2 && tap_ctrl.mask_bottom) ||
                (c == 0 && tap_ctrl.mask_left) || (c == 2 && tap_ctrl.mask_right)) begin
               masked[r*3 + c] = '0;
            end else begin
               masked[r*3 + c] = window_taps[r*3 + c];
            end
         end
      end
      corner_sum = SUM_W'(masked[0]) + SUM_W'(masked[2]) +
                   SUM_W'(masked[6]) + SUM_W'(masked[8]);
      side_sum   = SUM_W'(masked[1]) + SUM_W'(masked[3]) +
                   SUM_W'(masked[5]) + SUM_W'(masked[7]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff  <= tap_valid;
         prod_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tap_valid) begin
         corner_sum_ff <= corner_sum;
         side_sum_ff   <= side_sum;
         center_ff     <= SUM_W'(masked[4]);
         sum_hot_ff    <= tap_ctrl.hot;
         sum_last_ff   <= tap_ctrl.last;
      end
      if (advance && sum_valid_ff) begin
         corner_prod_ff <= PROD_W'(corner_sum_ff) * PROD_W'(coef.weight_corner);
         side_prod_ff   <= PROD_W'(side_sum_ff) * PROD_W'(coef.weight_side);
         center_prod_ff <= PROD_W'(center_ff) * PROD_W'(coef.weight_middle);
         prod_hot_ff    <= sum_hot_ff;
         prod_last_ff   <= sum_last_ff;
      end
   end

   // Q12.24 sum, round half up to Q8.8, saturate
   always_comb begin
      acc     = ACC_W'(corner_prod_ff) + ACC_W'(side_prod_ff) + ACC_W'(center_prod_ff) +
                ROUND_HALF;
      rounded = acc[ACC_W-1:hds_pkg::WEIGHT_BITS];
      if (rounded > RES_W'(hds_pkg::TEMP_MAX)) begin
         saturated = hds_pkg::TEMP_MAX;
      end else begin
         saturated = rounded[hds_pkg::TEMP_BITS-1:0];
      end
      res_payload.new_temp   = prod_hot_ff ? coef.hot_value : saturated;
      res_payload.frame_last = prod_last_ff;
   end

   assign res_valid = prod_valid_ff;

endmodule
